>>> rtl/iirdf2_pkg.sv
// ----------------------------------------------------------------------------
// iirdf2_pkg
// Shared types, constants and microcode table of the direct form II IIR filter.
// ----------------------------------------------------------------------------
package iirdf2_pkg;

    localparam int COEFF_COUNT_DEF = 5;
    localparam int FRAC_BITS_DEF   = 24;

    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_B0_B1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B2_B3 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B4    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1_A2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A3_A4 = 3'd4;

    typedef enum logic [2:0] {
        ST_FETCH,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_B0,
        ST_OUT
    } step_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_A,
        MUL_B,
        MUL_B0
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_SUB_W,
        ACC_ADD_Y
    } acc_op_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_SAMPLE,
        COND_TAP_MORE,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     tap_inc;
        logic     accept;
        logic     fire;
        cond_t    cond;
        step_t    target;
    } ucode_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     load;
        logic     clear;
        logic     fire;
    } dp_ctrl_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t cw;
        cw = '{mul_sel: MUL_NONE, acc_op: ACC_NONE, tap_inc: 1'b0, accept: 1'b0,
               fire: 1'b0, cond: COND_ALWAYS, target: ST_FETCH};
        unique case (step)
            ST_FETCH:
            begin
                cw.accept = 1'b1;
                cw.cond   = COND_SAMPLE;
                cw.target = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                cw.mul_sel = MUL_A;
                cw.acc_op  = ACC_ADD_Y;
                cw.cond    = COND_ALWAYS;
                cw.target  = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cw.mul_sel = MUL_B;
                cw.acc_op  = ACC_SUB_W;
                cw.tap_inc = 1'b1;
                cw.cond    = COND_TAP_MORE;
                cw.target  = ST_MUL_A;
            end
            ST_MUL_B0:
            begin
                cw.mul_sel = MUL_B0;
                cw.acc_op  = ACC_ADD_Y;
                cw.cond    = COND_ALWAYS;
                cw.target  = ST_OUT;
            end
            ST_OUT:
            begin
                cw.fire   = 1'b1;
                cw.cond   = COND_OUT_FREE;
                cw.target = ST_FETCH;
            end
            default:
            begin
                cw.target = ST_FETCH;
            end
        endcase
        return cw;
    endfunction

endpackage

>>> rtl/iirdf2_sequencer.sv
// ----------------------------------------------------------------------------
// iirdf2_sequencer
// Step counter, tap counter and microcode table; issues one control word a cycle.
// ----------------------------------------------------------------------------
module iirdf2_sequencer
    import iirdf2_pkg::*;
#(
    parameter int COEFF_COUNT = COEFF_COUNT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_mode,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_ctrl_t   ctrl,
    output logic [((COEFF_COUNT > 2) ? $clog2(COEFF_COUNT - 1) : 1)-1:0] tap
);

    localparam int TAPS  = COEFF_COUNT - 1;
    localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;

    step_t              step_reg, step_next;
    logic [TAP_W-1:0]   tap_reg, tap_next;
    ucode_t             cw;
    logic               last_tap;
    logic               beat;

    assign cw       = ucode_rom(step_reg);
    assign last_tap = (tap_reg == TAP_W'(TAPS - 1));
    assign beat     = cw.accept && in_valid;

    // next step
    always_comb
    begin
        step_next = step_reg;
        unique case (cw.cond)
            COND_ALWAYS:   step_next = cw.target;
            COND_SAMPLE:   step_next = (beat && !in_mode) ? cw.target : step_reg;
            COND_TAP_MORE: step_next = !last_tap ? cw.target : step_t'(step_reg + 3'd1);
            COND_OUT_FREE: step_next = status.out_free ? cw.target : step_reg;
            default:       step_next = ST_FETCH;
        endcase
    end

    always_comb
    begin
        tap_next = tap_reg;
        if (beat && !in_mode)
        begin
            tap_next = '0;
        end
        else if (cw.tap_inc && !last_tap)
        begin
            tap_next = tap_reg + TAP_W'(1);
        end
    end

    // control outputs
    always_comb
    begin
        in_ready     = cw.accept;
        ctrl.mul_sel = cw.mul_sel;
        ctrl.acc_op  = cw.acc_op;
        ctrl.load    = beat && !in_mode;
        ctrl.clear   = beat && in_mode;
        ctrl.fire    = cw.fire && status.out_free;
    end

    assign tap = tap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_FETCH;
            tap_reg  <= '0;
        end
        else
        begin
            step_reg <= step_next;
            tap_reg  <= tap_next;
        end
    end

`ifndef SYNTHESIS
    a_load_starts_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_mode) |=> (step_reg == ST_MUL_A && tap_reg == '0))
        else $error("filter beat did not start the tap loop at tap zero");

    a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        tap_reg <= TAP_W'(TAPS - 1))
        else $error("tap counter beyond last tap");

    a_b0_after_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_MUL_B0) |-> ($past(step_reg) == ST_MUL_B && last_tap))
        else $error("b0 product issued before the tap loop finished");
`endif

endmodule

>>> rtl/iirdf2_datapath.sv
// ----------------------------------------------------------------------------
// iirdf2_datapath
// Coefficient registers, delay line, shared multiplier, accumulators and
// output register.
// ----------------------------------------------------------------------------
module iirdf2_datapath
    import iirdf2_pkg::*;
#(
    parameter int COEFF_COUNT = COEFF_COUNT_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  dp_ctrl_t              ctrl,
    input  logic [((COEFF_COUNT > 2) ? $clog2(COEFF_COUNT - 1) : 1)-1:0] tap,
    input  logic [DATA_W-1:0]     sample_in,
    output dp_status_t            status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_W-1:0]     sample_out
);

    localparam int TAPS = COEFF_COUNT - 1;

    logic [DATA_W-1:0]          b0_reg;
    logic [DATA_W-1:0]          b_reg [TAPS];
    logic [DATA_W-1:0]          a_reg [TAPS];
    logic [DATA_W-1:0]          dl_reg [TAPS];
    logic [DATA_W-1:0]          acc_w_reg;
    logic [DATA_W-1:0]          acc_y_reg;
    logic [DATA_W-1:0]          prod_reg;
    logic [DATA_W-1:0]          out_data_reg;
    logic                       out_valid_reg;
    logic [DATA_W-1:0]          cfg_lo;
    logic [DATA_W-1:0]          cfg_hi;
    logic signed [DATA_W-1:0]   mul_x;
    logic signed [DATA_W-1:0]   mul_y;
    logic signed [2*DATA_W-1:0] mul_full;
    logic [DATA_W-1:0]          mul_q;
    logic                       out_free;

    assign cfg_lo = cfg_data[DATA_W-1:0];
    assign cfg_hi = cfg_data[CFG_DATA_W-1:DATA_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= '0;
            for (int k = 0; k < TAPS; k++)
            begin
                b_reg[k] <= '0;
                a_reg[k] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_B0_B1)
            begin
                b0_reg <= cfg_lo;
            end
            for (int k = 0; k < TAPS; k++)
            begin
                // b1 high of first pair, b2 low of second, and so on
                if (cfg_index == CFG_IDX_W'(REG_B0_B1 + ((k + 1) >> 1)))
                begin
                    b_reg[k] <= (((k + 1) & 1) != 0) ? cfg_hi : cfg_lo;
                end
                if (cfg_index == CFG_IDX_W'(REG_A1_A2 + (k >> 1)))
                begin
                    a_reg[k] <= ((k & 1) != 0) ? cfg_hi : cfg_lo;
                end
            end
        end
    end

    // shared multiplier operands
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        unique case (ctrl.mul_sel)
            MUL_NONE:
            begin
                mul_x = '0;
                mul_y = '0;
            end
            MUL_A:
            begin
                mul_x = $signed(a_reg[tap]);
                mul_y = $signed(dl_reg[tap]);
            end
            MUL_B:
            begin
                mul_x = $signed(b_reg[tap]);
                mul_y = $signed(dl_reg[tap]);
            end
            MUL_B0:
            begin
                mul_x = $signed(b0_reg);
                mul_y = $signed(acc_w_reg);
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign mul_full = mul_x * mul_y;
    assign mul_q    = DATA_W'(mul_full >>> FRAC_BITS);
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= '0;
        end
        else if (ctrl.mul_sel != MUL_NONE)
        begin
            prod_reg <= mul_q;
        end

        if (ctrl.load)
        begin
            acc_w_reg <= sample_in;
            acc_y_reg <= '0;
        end
        else
        begin
            unique case (ctrl.acc_op)
                ACC_NONE:  acc_w_reg <= acc_w_reg;
                ACC_SUB_W: acc_w_reg <= acc_w_reg - prod_reg;
                ACC_ADD_Y: acc_y_reg <= acc_y_reg + prod_reg;
                default:   acc_w_reg <= acc_w_reg;
            endcase
        end

        if (ctrl.fire)
        begin
            out_data_reg <= acc_y_reg + prod_reg;
        end
    end

    // delay line, newest tap first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                dl_reg[k] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                dl_reg[k] <= '0;
            end
        end
        else if (ctrl.fire)
        begin
            dl_reg[0] <= acc_w_reg;
            for (int k = 1; k < TAPS; k++)
            begin
                dl_reg[k] <= dl_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = out_free;
    assign out_valid       = out_valid_reg;
    assign sample_out      = out_data_reg;

`ifndef SYNTHESIS
    a_fire_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.fire |-> (!out_valid_reg || out_ready))
        else $error("result written over an untaken beat");

    a_no_clear_mid_sample: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |-> (ctrl.mul_sel == MUL_NONE && !ctrl.fire && !ctrl.load))
        else $error("clear issued while a sample is in work");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("waiting result beat changed before it was taken");
`endif

endmodule

>>> rtl/iir_direct_form2_filter.sv
// ----------------------------------------------------------------------------
// iir_direct_form2_filter
// Fourth-order direct form II IIR filter, signed Q24 in 32-bit words, run by a
// microcoded sequencer over one shared multiply-accumulate datapath.
//
//  channel   dir   handshake            payload
//  s_*       in    s_tvalid/s_tready    s_tuser: mode, s_tdata: sample_in
//  m_*       out   m_tvalid/m_tready    m_tdata: sample_out
//  cfg_*     in    cfg_wr_en            cfg_index, cfg_data (64 bit)
//
//  a filter beat runs the tap loop, the b0 product and the output step before
//  the next acceptance, with every product taken from the single shared multiplier
//  a clear beat zeroes the delay line and gives no result
//  the result waits in an output register; the sequencer holds only when that
//  register is still full at the final step
//  asynchronous active-low reset zeroes coefficients and delay line
// ----------------------------------------------------------------------------
module iir_direct_form2_filter
    import iirdf2_pkg::*;
#(
    parameter int COEFF_COUNT = COEFF_COUNT_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // sample_in
    input  logic [0:0]            s_tuser,   // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,   // sample_out
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int TAPS  = COEFF_COUNT - 1;
    localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;

    dp_ctrl_t         ctrl;
    dp_status_t       status;
    logic [TAP_W-1:0] tap;

    iirdf2_sequencer #(
        .COEFF_COUNT (COEFF_COUNT)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser[0]),
        .in_ready (s_tready),
        .status   (status),
        .ctrl     (ctrl),
        .tap      (tap)
    );

    iirdf2_datapath #(
        .COEFF_COUNT (COEFF_COUNT),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .ctrl       (ctrl),
        .tap        (tap),
        .sample_in  (s_tdata),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .sample_out (m_tdata)
    );

endmodule
